/* rtl/rc4sc_pkg.sv */
// rc4sc_pkg: shared types and constants for the rc4 stream cipher unit
// controller state encoding, command and status structs
// no dependencies
package rc4sc_pkg;

	localparam int BYTE_W     = 8;
	localparam int PERM_DEPTH = 256;
	localparam int PERM_AW    = 8;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_KS_RD,
		ST_KS_J,
		ST_KS_WK,
		ST_KS_WJ,
		ST_EC_J,
		ST_EC_WI,
		ST_EC_OUT
	} state_t;

	// one bit per datapath action; a state may raise more than one of them
	typedef struct packed {
		logic key_wr;
		logic sched_init;
		logic ks_rd;
		logic ks_upd_j;
		logic ks_wr_k;
		logic ks_wr_j;
		logic sched_end;
		logic ec_start;
		logic ec_upd_j;
		logic ec_wr_i;
		logic ec_wr_j;
		logic ec_out;
	} cmd_t;

	typedef struct packed {
		logic k_last;
		logic out_free;
	} sts_t;

endpackage

/* rtl/rc4_stream_cipher_unit.sv */
// rc4_stream_cipher_unit: top level of the byte-wide rc4 cipher
// depends on rc4sc_pkg, rc4sc_ctrl, rc4sc_datapath
//
// channel   dir  signals                               role
// s_*       in   tvalid tready tdata tlast tuser        key or text byte
// m_*       out  tvalid tready tdata                    ciphered byte
//
// a key byte is taken in the idle state; a text byte takes its transaction and
// three s-box steps set by the single read and write port, its result valid in
// the output register after the last step. a key byte with tlast starts the key
// schedule: read, update-j, write-k, write-j per s-box entry, no input taken.
// after reset the s-box reads as the identity through per-entry valid bits.
// a full output register holds the next text byte at its last step.
module rc4_stream_cipher_unit #(
	parameter int MAX_KEY_BYTES = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] data_byte
	input  logic       s_tlast,
	input  logic       s_tuser,   // [0] func
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata    // [7:0] out_byte
);
	import rc4sc_pkg::*;

	cmd_t cmd;
	sts_t sts;

	rc4sc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tlast  (s_tlast),
		.s_tuser  (s_tuser),
		.sts      (sts),
		.cmd      (cmd)
	);

	rc4sc_datapath #(
		.MAX_KEY_BYTES (MAX_KEY_BYTES)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.in_byte  (s_tdata),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata),
		.sts      (sts)
	);

endmodule

/* rtl/rc4sc_ctrl.sv */
// rc4sc_ctrl: sequencer for key loading, key schedule and keystream steps
// depends on rc4sc_pkg (state_t, cmd_t, sts_t)
module rc4sc_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	input  logic            s_tlast,
	input  logic            s_tuser,
	input  rc4sc_pkg::sts_t sts,
	output rc4sc_pkg::cmd_t cmd
);
	import rc4sc_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					if (s_tuser) begin
						cmd.ec_start = 1'b1;
						state_d      = ST_EC_J;
					end else begin
						cmd.key_wr = 1'b1;
						if (s_tlast) begin
							cmd.sched_init = 1'b1;
							state_d        = ST_KS_RD;
						end
					end
				end
			end
			ST_KS_RD: begin
				cmd.ks_rd = 1'b1;
				state_d   = ST_KS_J;
			end
			ST_KS_J: begin
				cmd.ks_upd_j = 1'b1;
				state_d      = ST_KS_WK;
			end
			ST_KS_WK: begin
				cmd.ks_wr_k = 1'b1;
				state_d     = ST_KS_WJ;
			end
			ST_KS_WJ: begin
				cmd.ks_wr_j = 1'b1;
				if (sts.k_last) begin
					cmd.sched_end = 1'b1;
					state_d       = ST_IDLE;
				end else begin
					state_d = ST_KS_RD;
				end
			end
			ST_EC_J: begin
				cmd.ec_upd_j = 1'b1;
				state_d      = ST_EC_WI;
			end
			ST_EC_WI: begin
				cmd.ec_wr_i = 1'b1;
				state_d     = ST_EC_OUT;
			end
			ST_EC_OUT: begin
				// holds here while the output register is still full
				cmd.ec_wr_j = 1'b1;
				if (sts.out_free) begin
					cmd.ec_out = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

/* rtl/rc4sc_datapath.sv */
// rc4sc_datapath: s-box and key store memories, indices, output register
// depends on rc4sc_pkg (cmd_t, sts_t, widths)
module rc4sc_datapath #(
	parameter int MAX_KEY_BYTES = 256
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rc4sc_pkg::cmd_t               cmd,
	input  logic [rc4sc_pkg::BYTE_W-1:0]  in_byte,
	input  logic                          m_tready,
	output logic                          m_tvalid,
	output logic [rc4sc_pkg::BYTE_W-1:0]  m_tdata,
	output rc4sc_pkg::sts_t               sts
);
	import rc4sc_pkg::*;

	localparam int CNT_W  = $clog2(MAX_KEY_BYTES + 1);
	localparam int KIDX_W = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;

	// s-box memory, an entry without its valid bit reads as its own index
	logic [BYTE_W-1:0]     perm_mem [PERM_DEPTH];
	logic [PERM_DEPTH-1:0] pvld_q;
	logic [BYTE_W-1:0]     prd_q;
	logic                  prd_vld_q;
	logic [PERM_AW-1:0]    prd_addr_q;
	logic [BYTE_W-1:0]     perm_rd;

	logic [BYTE_W-1:0]     key_mem [MAX_KEY_BYTES];
	logic [BYTE_W-1:0]     krd_q;

	logic [CNT_W-1:0]      key_cnt_q;
	logic [KIDX_W-1:0]     kk_q;
	logic [PERM_AW-1:0]    k_q;
	logic [PERM_AW-1:0]    i_q;
	logic [PERM_AW-1:0]    j_q;
	logic [BYTE_W-1:0]     si_q;
	logic [BYTE_W-1:0]     sj_q;
	logic [BYTE_W-1:0]     text_q;
	logic                  t_i_q;
	logic                  t_j_q;
	logic [BYTE_W-1:0]     out_q;
	logic                  out_vld_q;

	logic                  pr_en;
	logic [PERM_AW-1:0]    pr_addr;
	logic                  pw_en;
	logic [PERM_AW-1:0]    pw_addr;
	logic [BYTE_W-1:0]     pw_data;
	logic [PERM_AW-1:0]    j_ks;
	logic [PERM_AW-1:0]    j_ec;
	logic [PERM_AW-1:0]    t_idx;
	logic [CNT_W-1:0]      kk_inc;
	logic                  kk_wrap;
	logic                  key_room;
	logic [BYTE_W-1:0]     ks_byte;

	assign perm_rd  = prd_vld_q ? prd_q : prd_addr_q;
	assign j_ks     = j_q + perm_rd + krd_q;
	assign j_ec     = j_q + perm_rd;
	assign t_idx    = si_q + perm_rd;
	assign kk_inc   = CNT_W'(kk_q) + CNT_W'(1);
	assign kk_wrap  = (kk_inc == key_cnt_q);
	assign key_room = (key_cnt_q < CNT_W'(MAX_KEY_BYTES));

	// swap already applied for the slots just exchanged
	assign ks_byte = t_j_q ? si_q : (t_i_q ? sj_q : perm_rd);

	assign pr_en = cmd.ks_rd | cmd.ks_upd_j | cmd.ec_start | cmd.ec_upd_j | cmd.ec_wr_i;
	assign pw_en = cmd.ks_wr_k | cmd.ks_wr_j | cmd.ec_wr_i | cmd.ec_wr_j;

	always_comb begin
		pr_addr = '0;
		if (cmd.ks_rd) begin
			pr_addr = k_q;
		end else if (cmd.ks_upd_j) begin
			pr_addr = j_ks;
		end else if (cmd.ec_start) begin
			pr_addr = i_q + PERM_AW'(1);
		end else if (cmd.ec_upd_j) begin
			pr_addr = j_ec;
		end else if (cmd.ec_wr_i) begin
			pr_addr = t_idx;
		end
	end

	always_comb begin
		pw_addr = '0;
		pw_data = '0;
		if (cmd.ks_wr_k) begin
			pw_addr = k_q;
			pw_data = perm_rd;
		end else if (cmd.ec_wr_i) begin
			pw_addr = i_q;
			pw_data = perm_rd;
		end else if (cmd.ks_wr_j || cmd.ec_wr_j) begin
			pw_addr = j_q;
			pw_data = si_q;
		end
	end

	always_ff @(posedge clk) begin
		if (pw_en) begin
			perm_mem[pw_addr] <= pw_data;
		end
		if (pr_en) begin
			prd_q      <= perm_mem[pr_addr];
			prd_vld_q  <= pvld_q[pr_addr];
			prd_addr_q <= pr_addr;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.key_wr && key_room) begin
			key_mem[key_cnt_q[KIDX_W-1:0]] <= in_byte;
		end
		if (cmd.ks_rd) begin
			krd_q <= key_mem[kk_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pvld_q <= '0;
		end else if (cmd.sched_init) begin
			pvld_q <= '0;
		end else if (pw_en) begin
			pvld_q[pw_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_cnt_q <= '0;
			i_q       <= '0;
			j_q       <= '0;
		end else begin
			if (cmd.key_wr && key_room) begin
				key_cnt_q <= key_cnt_q + CNT_W'(1);
			end
			if (cmd.sched_init) begin
				j_q <= '0;
			end
			if (cmd.ks_upd_j) begin
				j_q <= j_ks;
			end
			if (cmd.ec_start) begin
				i_q <= i_q + PERM_AW'(1);
			end
			if (cmd.ec_upd_j) begin
				j_q <= j_ec;
			end
			if (cmd.sched_end) begin
				key_cnt_q <= '0;
				i_q       <= '0;
				j_q       <= '0;
			end
		end
	end

	// schedule loop indices and per-step holding registers
	always_ff @(posedge clk) begin
		if (cmd.sched_init) begin
			k_q  <= '0;
			kk_q <= '0;
		end
		if (cmd.ks_wr_j) begin
			k_q  <= k_q + PERM_AW'(1);
			kk_q <= kk_wrap ? '0 : kk_inc[KIDX_W-1:0];
		end
		if (cmd.ks_upd_j || cmd.ec_upd_j) begin
			si_q <= perm_rd;
		end
		if (cmd.ec_start) begin
			text_q <= in_byte;
		end
		if (cmd.ec_wr_i) begin
			sj_q  <= perm_rd;
			t_i_q <= (t_idx == i_q);
			t_j_q <= (t_idx == j_q);
		end
		if (cmd.ec_out) begin
			out_q <= text_q ^ ks_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.ec_out) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	assign m_tvalid     = out_vld_q;
	assign m_tdata      = out_q;
	assign sts.k_last   = (k_q == PERM_AW'(PERM_DEPTH - 1));
	assign sts.out_free = !out_vld_q || m_tready;

endmodule
